// ===== hdl/taus_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taus_pkg: shared types and constants of the combined Tausworthe generator
// Holds the command bundle, controller states, constants and the step functions.
// ----------------------------------------------------------------------------
package taus_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] LCG_MULT = 32'd69069;

    localparam int unsigned WARMUP_STEPS = 6;
    localparam int unsigned WARM_CNT_W   = $clog2(WARMUP_STEPS);

    // Action codes carried on tuser
    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    localparam logic [WORD_W-1:0] MASK_ONE   = 32'hFFFF_FFFE;
    localparam logic [WORD_W-1:0] MASK_TWO   = 32'hFFFF_FFF8;
    localparam logic [WORD_W-1:0] MASK_THREE = 32'hFFFF_FFF0;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_WARM
    } state_t;

    typedef struct packed {
        logic load_seed;  // capture (base seed + index) into the seed register
        logic mul_one;    // comp_one <= 69069 * seed
        logic mul_two;    // comp_two <= 69069 * comp_one
        logic mul_three;  // comp_three <= 69069 * comp_two
        logic step;       // advance all three components once
        logic load_out;   // load the output register with the stepped XOR
    } dp_cmd_t;

    function automatic word_t step_one(input word_t w);
        word_t mixed;
        begin
            mixed = (w << 13) ^ w;
            return ((w & MASK_ONE) << 12) ^ (mixed >> 19);
        end
    endfunction

    function automatic word_t step_two(input word_t w);
        word_t mixed;
        begin
            mixed = (w << 2) ^ w;
            return ((w & MASK_TWO) << 4) ^ (mixed >> 25);
        end
    endfunction

    function automatic word_t step_three(input word_t w);
        word_t mixed;
        begin
            mixed = (w << 3) ^ w;
            return ((w & MASK_THREE) << 17) ^ (mixed >> 11);
        end
    endfunction

endpackage

// ===== hdl/taus_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taus_dp: generator datapath
// Base seed register, seed adder, shared multiplier, three component words
// with their step logic, and the output word register.
// ----------------------------------------------------------------------------
module taus_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  taus_pkg::dp_cmd_t      cmd,
    input  logic                   cfg_we,
    input  taus_pkg::word_t        cfg_data,
    input  taus_pkg::word_t        element_index,
    output taus_pkg::word_t        random_word
);
    import taus_pkg::*;

    word_t base_seed_reg;
    word_t seed_reg;
    word_t seed_next;
    word_t base_fixed;
    word_t seed_sum;
    word_t comp_one_reg;
    word_t comp_one_next;
    word_t comp_two_reg;
    word_t comp_two_next;
    word_t comp_three_reg;
    word_t comp_three_next;
    word_t out_reg;
    word_t out_next;
    word_t mul_in;
    word_t mul_prod;
    word_t one_stepped;
    word_t two_stepped;
    word_t three_stepped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_seed_reg <= word_t'(1);
        end
        else if (cfg_we)
        begin
            base_seed_reg <= cfg_data;
        end
    end

    // Zero base and zero sum are both taken as one
    always_comb
    begin
        base_fixed = (base_seed_reg == '0) ? word_t'(1) : base_seed_reg;
        seed_sum   = base_fixed + element_index;
        seed_next  = cmd.load_seed ? ((seed_sum == '0) ? word_t'(1) : seed_sum) : seed_reg;
    end

    always_comb
    begin
        if (cmd.mul_two)
        begin
            mul_in = comp_one_reg;
        end
        else if (cmd.mul_three)
        begin
            mul_in = comp_two_reg;
        end
        else
        begin
            mul_in = seed_reg;
        end
        mul_prod = mul_in * LCG_MULT;
    end

    always_comb
    begin
        one_stepped   = step_one(comp_one_reg);
        two_stepped   = step_two(comp_two_reg);
        three_stepped = step_three(comp_three_reg);

        comp_one_next   = comp_one_reg;
        comp_two_next   = comp_two_reg;
        comp_three_next = comp_three_reg;
        if (cmd.step)
        begin
            comp_one_next   = one_stepped;
            comp_two_next   = two_stepped;
            comp_three_next = three_stepped;
        end
        if (cmd.mul_one)
        begin
            comp_one_next = mul_prod;
        end
        if (cmd.mul_two)
        begin
            comp_two_next = mul_prod;
        end
        if (cmd.mul_three)
        begin
            comp_three_next = mul_prod;
        end

        out_next = cmd.load_out ? (one_stepped ^ two_stepped ^ three_stepped) : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_one_reg   <= '0;
            comp_two_reg   <= '0;
            comp_three_reg <= '0;
        end
        else
        begin
            comp_one_reg   <= comp_one_next;
            comp_two_reg   <= comp_two_next;
            comp_three_reg <= comp_three_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        out_reg  <= out_next;
    end

    assign random_word = out_reg;

endmodule

// ===== hdl/taus_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taus_ctrl: generator controller
// Accepts requests, sequences the seeding multiplies and warm-up steps, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module taus_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_action,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output taus_pkg::dp_cmd_t      cmd
);
    import taus_pkg::*;

    localparam logic [WARM_CNT_W-1:0] WARM_LAST = WARM_CNT_W'(WARMUP_STEPS - 1);

    state_t                state_reg;
    state_t                state_next;
    logic [WARM_CNT_W-1:0] warm_cnt_reg;
    logic [WARM_CNT_W-1:0] warm_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;
    logic                  accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            warm_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            warm_cnt_reg  <= warm_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free      = !out_valid_reg || m_tready;
        s_tready      = (state_reg == ST_IDLE) && out_free;
        accept        = s_tvalid && s_tready;
        state_next    = state_reg;
        warm_cnt_next = warm_cnt_reg;
        cmd           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_action == ACT_DRAW)
                    begin
                        cmd.step     = 1'b1;
                        cmd.load_out = 1'b1;
                    end
                    else
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                cmd.mul_one = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_two = 1'b1;
                state_next  = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul_three = 1'b1;
                warm_cnt_next = '0;
                state_next    = ST_WARM;
            end
            ST_WARM:
            begin
                if (warm_cnt_reg != WARM_LAST)
                begin
                    cmd.step      = 1'b1;
                    warm_cnt_next = warm_cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    // last warm-up step also delivers the seed result
                    cmd.step     = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("request taken outside idle");

    a_seed_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_action == ACT_SEED) |=> (state_reg == ST_MUL1))
        else $error("seed request did not start multiply sequence");

    a_warm_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL3) |=> (state_reg == ST_WARM && warm_cnt_reg == '0))
        else $error("warm-up did not start from zero");

    a_warm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WARM && warm_cnt_reg == WARM_LAST && out_free)
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("seed result not delivered after warm-up");

    a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_action == ACT_DRAW) |=> out_valid_reg)
        else $error("draw request produced no result");

endmodule

// ===== hdl/tausworthe_rng_with_seeding.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tausworthe_rng_with_seeding: combined three-component Tausworthe generator
// Seed requests load the components through a 69069 multiplier chain and
// six warm-up steps; draw requests advance the components once.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata = element_index, s_tuser = action
//  m_*      out  m_tvalid/m_tready  m_tdata = random_word
//  cfg_*    in   cfg_valid/cfg_ready cfg_data = base_seed
//
//  Draws stream back to back, one per cycle, from the single step unit, while
//  the output is taken. A seed reaches its result through the sum, three
//  passes through the shared multiplier and six warm-up steps.
//  Reset clears the components to zero and sets base_seed to one.
//  A stalled output holds its word; the next request is taken in the cycle the
//  output is taken. cfg_ready is always high.
// ----------------------------------------------------------------------------
module tausworthe_rng_with_seeding
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_index
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] random_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import taus_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    taus_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    taus_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .element_index (s_tdata),
        .random_word   (m_tdata)
    );

endmodule

// ===== tb/sv/taus_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taus_stream_checker: word predictor and scoreboard for the Tausworthe block
// Watches the request, result and base seed channels, keeps its own copy of
// the three component words, and compares every returned word in order.
// ----------------------------------------------------------------------------
module taus_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_index
    input  logic        s_tuser,   // [0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] random_word
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          fail_cnt,
    output int          words_pending
);

    localparam int REPORT_LIMIT = 10;

    logic [31:0] comp_one_q;
    logic [31:0] comp_two_q;
    logic [31:0] comp_three_q;
    logic [31:0] base_seed_q;
    logic [31:0] want_word;
    logic [31:0] expected_words [$];
    int          mismatch_cnt;

    function automatic logic [31:0] tausworthe_shift(input logic [31:0] w, input int a,
                                                     input int b, input logic [31:0] mask,
                                                     input int d);
        return ((w & mask) << d) ^ (((w << a) ^ w) >> b);
    endfunction

    function automatic void advance_components();
        comp_one_q   = tausworthe_shift(comp_one_q, 13, 19, taus_pkg::MASK_ONE, 12);
        comp_two_q   = tausworthe_shift(comp_two_q, 2, 25, taus_pkg::MASK_TWO, 4);
        comp_three_q = tausworthe_shift(comp_three_q, 3, 11, taus_pkg::MASK_THREE, 17);
    endfunction

    function automatic logic [31:0] predict_word(input logic act, input logic [31:0] idx);
        logic [31:0] seed;
        if (act == taus_pkg::ACT_SEED)
        begin
            // zero base seed and zero sum both fold to one
            seed = (base_seed_q == 32'd0) ? 32'd1 : base_seed_q;
            seed = seed + idx;
            if (seed == 32'd0)
            begin
                seed = 32'd1;
            end
            comp_one_q   = taus_pkg::LCG_MULT * seed;
            comp_two_q   = taus_pkg::LCG_MULT * comp_one_q;
            comp_three_q = taus_pkg::LCG_MULT * comp_two_q;
            repeat (taus_pkg::WARMUP_STEPS) advance_components();
        end
        else
        begin
            advance_components();
        end
        return comp_one_q ^ comp_two_q ^ comp_three_q;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_one_q    = 32'd0;
            comp_two_q    = 32'd0;
            comp_three_q  = 32'd0;
            base_seed_q   = 32'd1;
            mismatch_cnt  = 0;
            expected_words.delete();
            fail_cnt      <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_seed_q = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                expected_words.push_back(predict_word(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected random_word %08h, nothing pending",
                                 $time, m_tdata);
                    end
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (m_tdata !== want_word)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                        begin
                            $display("%0t: random_word mismatch: expected %08h, got %08h",
                                     $time, want_word, m_tdata);
                        end
                    end
                end
            end
            words_pending <= expected_words.size();
            fail_cnt      <= mismatch_cnt;
        end
    end

endmodule

// ===== tb/sv/tausworthe_rng_with_seeding_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tausworthe_rng_with_seeding_tb: stimulus and verdict for the generator
// Drives seed and draw requests under three idle patterns, changes the base
// seed between phases, and lets the stream checker score every word.
// ----------------------------------------------------------------------------
module tausworthe_rng_with_seeding_tb;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'd0;
    logic        s_tuser   = taus_pkg::ACT_SEED;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = 32'd0;

    int          fail_cnt;
    int          words_pending;
    int          send_idle_pct  = 25;
    int          recv_stall_pct = 65;
    logic [31:0] base_now       = 32'd1;
    int          seed_cnt       = 0;
    int          draw_cnt       = 0;
    int          cfg_cnt        = 0;

    tausworthe_rng_with_seeding i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    taus_stream_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_cnt      (fail_cnt),
        .words_pending (words_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_request(input logic act, input logic [31:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= idx;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (act == taus_pkg::ACT_SEED)
        begin
            seed_cnt++;
        end
        else
        begin
            draw_cnt++;
        end
    endtask

    // hold off until every request has its word and the seed pipeline is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_base_seed(input logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        base_now = value;
        cfg_cnt++;
    endtask

    function automatic logic [31:0] pick_index();
        logic [31:0] eff_base;
        eff_base = (base_now == 32'd0) ? 32'd1 : base_now;
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd0 - eff_base;  // wrap the sum to zero
            default: return $urandom;
        endcase
    endfunction

    // mostly a seed followed by a run of draws; sometimes seeds back to back
    task automatic run_traffic(input int n_items);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items)
        begin
            send_request(taus_pkg::ACT_SEED, pick_index());
            sent++;
            run_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            repeat (run_len)
            begin
                send_request(taus_pkg::ACT_DRAW, $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        int drain_cycles;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draws before any seed stay at zero
        send_request(taus_pkg::ACT_DRAW, 32'd0);
        send_request(taus_pkg::ACT_DRAW, 32'hFFFF_FFFF);
        send_request(taus_pkg::ACT_SEED, 32'd0);
        send_request(taus_pkg::ACT_DRAW, 32'h5555_5555);
        send_request(taus_pkg::ACT_DRAW, 32'hAAAA_AAAA);
        send_request(taus_pkg::ACT_DRAW, 32'd0);
        send_request(taus_pkg::ACT_SEED, 32'hFFFF_FFFF);
        send_request(taus_pkg::ACT_DRAW, 32'd0);

        // zero base seed folds to one
        write_base_seed(32'd0);
        send_request(taus_pkg::ACT_SEED, 32'd0);
        send_request(taus_pkg::ACT_DRAW, 32'd0);
        send_request(taus_pkg::ACT_SEED, 32'hFFFF_FFFF);
        send_request(taus_pkg::ACT_SEED, 32'd1);
        send_request(taus_pkg::ACT_DRAW, 32'd0);

        write_base_seed(32'hFFFF_FFFF);
        send_request(taus_pkg::ACT_SEED, 32'd1);
        send_request(taus_pkg::ACT_SEED, 32'd0);
        send_request(taus_pkg::ACT_DRAW, 32'd0);
        send_request(taus_pkg::ACT_SEED, 32'h7FFF_FFFF);
        send_request(taus_pkg::ACT_DRAW, 32'd0);

        write_base_seed($urandom);
        run_traffic(195);

        write_base_seed(32'h8000_0000);
        send_idle_pct  = 65;
        recv_stall_pct = 25;
        run_traffic(195);

        write_base_seed($urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_traffic(195);

        s_tvalid <= 1'b0;
        drain_cycles = 0;
        @(posedge clk);
        while (words_pending != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);

        if (words_pending != 0)
        begin
            $display("%0d expected words never arrived", words_pending);
        end
        $display("Covered %0d seed and %0d draw requests across %0d base seed writes,",
                 seed_cnt, draw_cnt, cfg_cnt);
        $display("under sender-heavy, receiver-heavy and gap-free traffic.");
        if (fail_cnt == 0 && words_pending == 0)
        begin
            $display("** tausworthe_rng_with_seeding: PASSED **");
        end
        else
        begin
            $display("** tausworthe_rng_with_seeding: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: simulation did not complete");
        $display("** tausworthe_rng_with_seeding: FAILED **");
        $finish;
    end

endmodule
